// ===== rtl/bgc_pkg.sv =====
// Shared types and constants for the button gesture classifier.
// Used by bgc_click, bgc_long and button_gesture_classifier; no dependencies.
`timescale 1ns / 1ps

package bgc_pkg;

    localparam int CFG_W           = 12;
    localparam int CFG_IDX_W       = 2;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [CFG_W-1:0] DCW_RESET = 12'd6;
    localparam logic [CFG_W-1:0] LPT_RESET = 12'd25;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DCW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LPT = 2'd1;

    typedef enum logic [2:0] {
        GEST_NONE   = 3'd0,
        GEST_SINGLE = 3'd1,
        GEST_DOUBLE = 3'd2,
        GEST_LONG   = 3'd3,
        GEST_START  = 3'd4
    } gesture_t;

    typedef struct packed {
        logic       press_seen;
        logic       press_counted;
        logic [1:0] press_tally;
    } click_flags_t;

endpackage

// ===== rtl/bgc_click.sv =====
// Click detector: counts presses and declares single and double clicks.
// Purely combinational next-state logic; depends on bgc_pkg.
`timescale 1ns / 1ps

module bgc_click #(
    parameter int COUNT_WIDTH = bgc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      pressed,
    input  logic [bgc_pkg::CFG_W-1:0] window,
    input  bgc_pkg::click_flags_t     flags,
    input  logic [COUNT_WIDTH-1:0]    gap,
    input  logic [COUNT_WIDTH-1:0]    hold,
    output bgc_pkg::click_flags_t     flags_next,
    output logic [COUNT_WIDTH-1:0]    gap_next,
    output logic [COUNT_WIDTH-1:0]    hold_next,
    output bgc_pkg::gesture_t         gesture
);
    import bgc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    logic                   seen1;
    logic                   counted1;
    logic [1:0]             tally1;
    logic [COUNT_WIDTH-1:0] gap1;
    logic [COUNT_WIDTH-1:0] hold1;

    always_comb
    begin
        hold1 = pressed ? ((hold == '1) ? hold : COUNT_WIDTH'(hold + 1'b1))
                        : '0;
        seen1    = flags.press_seen | pressed;
        counted1 = flags.press_counted;
        tally1   = flags.press_tally;
        gap1     = (gap == '1) ? gap : COUNT_WIDTH'(gap + 1'b1);

        flags_next = flags;
        gap_next   = gap;
        hold_next  = hold1;
        gesture    = GEST_NONE;

        if (!flags.press_counted && seen1)
        begin
            tally1   = (flags.press_tally == 2'd3) ? 2'd3 : 2'(flags.press_tally + 1'b1);
            counted1 = 1'b1;
        end

        if (!flags.press_counted && (tally1 == 2'd2))
        begin
            // Second press inside the window: the rest of this tick is skipped.
            flags_next.press_seen    = seen1;
            flags_next.press_counted = counted1;
            flags_next.press_tally   = 2'd0;
            gap_next                 = '0;
            gesture                  = GEST_DOUBLE;
        end
        else
        begin
            flags_next.press_seen    = pressed ? seen1 : 1'b0;
            flags_next.press_counted = pressed ? counted1 : 1'b0;
            flags_next.press_tally   = tally1;
            if (tally1 == 2'd1)
            begin
                if ((CMP_W'(gap1) > CMP_W'(window)) && (CMP_W'(hold1) < CMP_W'(window)))
                begin
                    flags_next.press_tally = 2'd0;
                    gap_next               = '0;
                    gesture                = GEST_SINGLE;
                end
                else if (CMP_W'(hold1) > CMP_W'(window))
                begin
                    flags_next.press_tally = 2'd0;
                    gap_next               = '0;
                end
                else
                begin
                    gap_next = gap1;
                end
            end
        end
    end

endmodule

// ===== rtl/bgc_long.sv =====
// Long-press detector: reports press start and repeating long press.
// Purely combinational next-state logic; depends on bgc_pkg.
`timescale 1ns / 1ps

module bgc_long #(
    parameter int COUNT_WIDTH = bgc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      pressed,
    input  logic [bgc_pkg::CFG_W-1:0] threshold,
    input  logic                      fired,
    input  logic [COUNT_WIDTH-1:0]    count,
    output logic                      fired_next,
    output logic [COUNT_WIDTH-1:0]    count_next,
    output bgc_pkg::gesture_t         gesture
);
    import bgc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    logic [COUNT_WIDTH-1:0] count1;

    always_comb
    begin
        if (!fired && pressed)
        begin
            count1 = (count == '1) ? count : COUNT_WIDTH'(count + 1'b1);
        end
        else
        begin
            count1 = '0;
        end

        if (CMP_W'(count1) > CMP_W'(threshold))
        begin
            fired_next = 1'b1;
            count_next = '0;
            gesture    = GEST_LONG;
        end
        else if (count1 == COUNT_WIDTH'(1))
        begin
            fired_next = fired;
            count_next = count1;
            gesture    = GEST_START;
        end
        else
        begin
            fired_next = 1'b0;
            count_next = count1;
            gesture    = GEST_NONE;
        end
    end

endmodule

// ===== rtl/button_gesture_classifier.sv =====
// Button gesture classifier top level: input register, gesture logic, result register.
// Each sample is held in the input register, and its gesture in the result register.
// Throughput: one item per cycle while the output is not stalled; the click and long-press update is combinational.
// Reset clears all detector state and loads the window and threshold defaults.
// Depends on bgc_pkg, bgc_click and bgc_long.
`timescale 1ns / 1ps

module button_gesture_classifier #(
    parameter int COUNT_WIDTH = bgc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          key_level,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    gesture,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bgc_pkg::CFG_W-1:0]     cfg_data
);
    import bgc_pkg::*;

    logic                   s1_valid_reg,  s1_valid_next;
    logic                   key_reg,       key_next;
    logic                   out_valid_reg, out_valid_next;
    gesture_t               gesture_reg,   gesture_next;
    logic [CFG_W-1:0]       dcw_reg,       dcw_next;
    logic [CFG_W-1:0]       lpt_reg,       lpt_next;
    click_flags_t           flags_reg,     flags_next;
    logic [COUNT_WIDTH-1:0] gap_reg,       gap_next;
    logic [COUNT_WIDTH-1:0] hold_reg,      hold_next;
    logic                   fired_reg,     fired_next;
    logic [COUNT_WIDTH-1:0] lhold_reg,     lhold_next;

    click_flags_t           click_flags;
    logic [COUNT_WIDTH-1:0] click_gap;
    logic [COUNT_WIDTH-1:0] click_hold;
    gesture_t               click_gesture;
    logic                   long_fired;
    logic [COUNT_WIDTH-1:0] long_count;
    gesture_t               long_gesture;

    logic pressed;
    logic advance;

    assign pressed   = ~key_reg;
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign gesture   = gesture_reg;
    assign cfg_ready = 1'b1;

    bgc_click #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_click (
        .pressed    (pressed),
        .window     (dcw_reg),
        .flags      (flags_reg),
        .gap        (gap_reg),
        .hold       (hold_reg),
        .flags_next (click_flags),
        .gap_next   (click_gap),
        .hold_next  (click_hold),
        .gesture    (click_gesture)
    );

    bgc_long #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_long (
        .pressed    (pressed),
        .threshold  (lpt_reg),
        .fired      (fired_reg),
        .count      (lhold_reg),
        .fired_next (long_fired),
        .count_next (long_count),
        .gesture    (long_gesture)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg;
        gesture_next   = gesture_reg;
        dcw_next       = dcw_reg;
        lpt_next       = lpt_reg;
        flags_next     = flags_reg;
        gap_next       = gap_reg;
        hold_next      = hold_reg;
        fired_next     = fired_reg;
        lhold_next     = lhold_reg;

        if (!in_stall)
        begin
            s1_valid_next = in_valid;
            key_next      = key_level;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
            flags_next     = click_flags;
            gap_next       = click_gap;
            hold_next      = click_hold;
            // The long-press detector only runs when the click detector is silent.
            if (click_gesture == GEST_NONE)
            begin
                fired_next   = long_fired;
                lhold_next   = long_count;
                gesture_next = long_gesture;
            end
            else
            begin
                gesture_next = click_gesture;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DCW: dcw_next = cfg_data;
                REG_LPT: lpt_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            dcw_reg       <= DCW_RESET;
            lpt_reg       <= LPT_RESET;
            flags_reg     <= '0;
            gap_reg       <= '0;
            hold_reg      <= '0;
            fired_reg     <= 1'b0;
            lhold_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            dcw_reg       <= dcw_next;
            lpt_reg       <= lpt_next;
            flags_reg     <= flags_next;
            gap_reg       <= gap_next;
            hold_reg      <= hold_next;
            fired_reg     <= fired_next;
            lhold_reg     <= lhold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        gesture_reg <= gesture_next;
    end

endmodule
